/* design/tsq_pkg.sv */
// Shared constants, types and codes of the touch stability qualifier.
// Used by every module of the block; depends on nothing.
`default_nettype none

package tsq_pkg;

  // window geometry
  localparam int WINDOW_DEPTH = 20;
  localparam int ADDR_W       = $clog2(WINDOW_DEPTH);

  // field widths
  localparam int COORD_W    = 12;
  localparam int DIST_W     = COORD_W + 1;
  localparam int SUM_W      = COORD_W + $clog2(WINDOW_DEPTH);
  localparam int SW_W       = 11;
  localparam int SPREAD_W   = 13;
  localparam int REARM_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int SAMPLE_W   = 2 * COORD_W;

  // no-touch marker that fills the window after reset
  localparam logic signed [COORD_W-1:0] NO_TOUCH = 12'sd2047;

  // register reset values
  localparam logic [SW_W-1:0]     SCREEN_WIDTH_RST = 11'd800;
  localparam logic [SPREAD_W-1:0] MAX_SPREAD_RST   = 13'd200;
  localparam logic [REARM_W-1:0]  REARM_COUNT_RST  = 8'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPREAD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REARM_COUNT  = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } sample_t;

  // pair read request into the window memory
  typedef struct packed {
    logic              en;
    logic              diag;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
  } rd_req_t;

  // registered pair read response
  typedef struct packed {
    logic    valid;
    logic    diag;
    sample_t a;
    sample_t b;
  } rd_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DIV_X,
    ST_DIV_Y,
    ST_EMIT
  } seq_state_e;

endpackage : tsq_pkg

`default_nettype wire

/* design/touch_stability_qualifier_unit.sv */
// Touch stability qualifier: 20-deep sample window, pairwise spread check, mean.
// Each input beat runs the pair reads, a drain, two divides (skipped when the window
// is unstable) and an emit; one beat in flight, the next input taken at the earliest
// the cycle after the emit, later while a waiting result holds the emit. Reset:
// window reads as the no-touch marker, re-arm counter zero, registers at defaults.
// Uses tsq_pkg and the three submodules.
`default_nettype none

module touch_stability_qualifier_unit
  import tsq_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // slave side, tdata: sample_x, sample_y
  input  wire logic                  s_tvalid_i,
  output logic                       s_tready_o,
  input  wire logic [SAMPLE_W-1:0]   s_tdata_i,
  // master side, tdata: avg_x, avg_y; tuser: stable, press
  output logic                       m_tvalid_o,
  input  wire logic                  m_tready_i,
  output logic [SAMPLE_W-1:0]        m_tdata_o,
  output logic [1:0]                 m_tuser_o,
  // configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WINDOW_DEPTH - 1);

  seq_state_e state_q, state_d;

  logic [SW_W-1:0]     screen_width_q;
  logic [SPREAD_W-1:0] max_spread_q;
  logic [REARM_W-1:0]  rearm_count_q;
  logic [REARM_W-1:0]  rearm_q, rearm_d;

  logic [ADDR_W-1:0] i_q, i_d, j_q, j_d;
  logic              accept, drained, slot_free, emit;
  logic              div_start, div_done;
  logic signed [SUM_W-1:0]   div_dividend;
  logic signed [COORD_W-1:0] div_quot;
  logic signed [COORD_W-1:0] avg_x_q, avg_y_q;

  rd_req_t rd_req;
  rd_rsp_t rd_rsp;
  logic    pair_fail, pair_busy;
  logic signed [SUM_W-1:0] sum_x, sum_y;

  logic                m_tvalid_q;
  logic [SAMPLE_W-1:0] m_tdata_q;
  logic [1:0]          m_tuser_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q <= SCREEN_WIDTH_RST;
      max_spread_q   <= MAX_SPREAD_RST;
      rearm_count_q  <= REARM_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SCREEN_WIDTH: screen_width_q <= cfg_data_i[SW_W-1:0];
        CFG_MAX_SPREAD:   max_spread_q   <= cfg_data_i[SPREAD_W-1:0];
        CFG_REARM_COUNT:  rearm_count_q  <= cfg_data_i[REARM_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept    = s_tvalid_i && s_tready_o;
  assign drained   = !rd_rsp.valid && !pair_busy;
  assign slot_free = !m_tvalid_q || m_tready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (s_tvalid_i) state_d = ST_WALK;
      ST_WALK:  if (i_q == LAST_ADDR && j_q == LAST_ADDR) state_d = ST_DRAIN;
      ST_DRAIN: if (drained) state_d = pair_fail ? ST_EMIT : ST_DIV_X;
      ST_DIV_X: if (div_done) state_d = ST_DIV_Y;
      ST_DIV_Y: if (div_done) state_d = ST_EMIT;
      ST_EMIT:  if (slot_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready_o     = 1'b0;
    rd_req.en      = 1'b0;
    rd_req.diag    = (i_q == j_q);
    rd_req.addr_a  = i_q;
    rd_req.addr_b  = j_q;
    div_start      = 1'b0;
    div_dividend   = sum_y;
    emit           = 1'b0;
    unique case (state_q)
      ST_IDLE:  s_tready_o = 1'b1;
      ST_WALK:  rd_req.en = 1'b1;
      ST_DRAIN: begin
        div_start    = drained && !pair_fail;
        div_dividend = sum_x;
      end
      ST_DIV_X: div_start = div_done;
      ST_DIV_Y: ;
      ST_EMIT:  emit = slot_free;
      default:  ;
    endcase
  end

  // pair walk over the upper triangle, diagonal included
  always_comb begin
    i_d = i_q;
    j_d = j_q;
    if (accept) begin
      i_d = '0;
      j_d = '0;
    end else if (state_q == ST_WALK) begin
      if (j_q == LAST_ADDR) begin
        if (i_q != LAST_ADDR) begin
          i_d = i_q + 1'b1;
          j_d = i_q + 1'b1;
        end
      end else begin
        j_d = j_q + 1'b1;
      end
    end
  end

  // re-arm counter
  always_comb begin
    rearm_d = rearm_q;
    if (emit) begin
      if (!pair_fail) begin
        rearm_d = (rearm_count_q == '0) ? '0 : rearm_count_q - 1'b1;
      end else if (rearm_q != '0) begin
        rearm_d = rearm_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      i_q        <= '0;
      j_q        <= '0;
      rearm_q    <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      rearm_q <= rearm_d;
      if (emit) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  // averages and output beat
  always_ff @(posedge clk_i) begin
    if (div_done && state_q == ST_DIV_X) begin
      avg_x_q <= div_quot;
    end
    if (div_done && state_q == ST_DIV_Y) begin
      avg_y_q <= div_quot;
    end
    if (emit) begin
      m_tuser_q <= {!pair_fail && (rearm_q == '0), !pair_fail};
      m_tdata_q <= pair_fail ? '0 : {avg_y_q, avg_x_q};
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;
  assign m_tuser_o  = m_tuser_q;

  tsq_window_mem u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (accept),
    .wr_data_i (sample_t'(s_tdata_i)),
    .rd_req_i  (rd_req),
    .rd_rsp_o  (rd_rsp)
  );

  tsq_pair_unit u_pair (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .clear_i        (accept),
    .rsp_i          (rd_rsp),
    .screen_width_i (screen_width_q),
    .max_spread_i   (max_spread_q),
    .fail_o         (pair_fail),
    .busy_o         (pair_busy),
    .sum_x_o        (sum_x),
    .sum_y_o        (sum_y)
  );

  tsq_div_unit u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

endmodule : touch_stability_qualifier_unit

`default_nettype wire

/* design/tsq_window_mem.sv */
// Circular sample window: one write port, two registered read ports.
// Entries never written read as the no-touch marker. Depends on tsq_pkg.
`default_nettype none

module tsq_window_mem
  import tsq_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    wr_en_i,
  input  wire sample_t wr_data_i,
  input  wire rd_req_t rd_req_i,
  output rd_rsp_t      rd_rsp_o
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WINDOW_DEPTH - 1);

  sample_t                 mem_q [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] vld_q, vld_d;
  logic [ADDR_W-1:0]       wr_ptr_q, wr_ptr_d;
  sample_t                 rd_a_q, rd_b_q;
  logic                    rd_va_q, rd_vb_q;
  logic                    rsp_valid_q, rsp_diag_q;

  // write pointer and per-entry valid bits
  always_comb begin
    vld_d    = vld_q;
    wr_ptr_d = wr_ptr_q;
    if (wr_en_i) begin
      vld_d[wr_ptr_q] = 1'b1;
      wr_ptr_d        = (wr_ptr_q == LAST_ADDR) ? '0 : wr_ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      wr_ptr_q    <= '0;
      rsp_valid_q <= 1'b0;
      rsp_diag_q  <= 1'b0;
    end else begin
      vld_q       <= vld_d;
      wr_ptr_q    <= wr_ptr_d;
      rsp_valid_q <= rd_req_i.en;
      rsp_diag_q  <= rd_req_i.diag;
    end
  end

  // storage write
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // registered reads
  always_ff @(posedge clk_i) begin
    if (rd_req_i.en) begin
      rd_a_q  <= mem_q[rd_req_i.addr_a];
      rd_b_q  <= mem_q[rd_req_i.addr_b];
      rd_va_q <= vld_q[rd_req_i.addr_a];
      rd_vb_q <= vld_q[rd_req_i.addr_b];
    end
  end

  // unwritten entries show the no-touch marker in both coordinates
  always_comb begin
    rd_rsp_o.valid = rsp_valid_q;
    rd_rsp_o.diag  = rsp_diag_q;
    rd_rsp_o.a     = rd_va_q ? rd_a_q : sample_t'{x: NO_TOUCH, y: NO_TOUCH};
    rd_rsp_o.b     = rd_vb_q ? rd_b_q : sample_t'{x: NO_TOUCH, y: NO_TOUCH};
  end

endmodule : tsq_window_mem

`default_nettype wire

/* design/tsq_pair_unit.sv */
// Shared pair unit: Manhattan distance and spread check per sample pair,
// plus width check and coordinate sums on diagonal pairs. Depends on tsq_pkg.
`default_nettype none

module tsq_pair_unit
  import tsq_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                clear_i,
  input  wire rd_rsp_t             rsp_i,
  input  wire logic [SW_W-1:0]     screen_width_i,
  input  wire logic [SPREAD_W-1:0] max_spread_i,
  output logic                     fail_o,
  output logic                     busy_o,
  output logic signed [SUM_W-1:0]  sum_x_o,
  output logic signed [SUM_W-1:0]  sum_y_o
);

  logic [COORD_W-1:0]      adx, ady;
  logic [DIST_W-1:0]       dist_d, dist_q;
  logic                    dist_v_q;
  logic                    wide_bad, spread_bad;
  logic                    fail_q, fail_d;
  logic signed [SUM_W-1:0] sum_x_q, sum_x_d, sum_y_q, sum_y_d;

  // absolute differences, larger minus smaller
  always_comb begin
    adx    = (rsp_i.a.x >= rsp_i.b.x) ? COORD_W'(rsp_i.a.x - rsp_i.b.x)
                                      : COORD_W'(rsp_i.b.x - rsp_i.a.x);
    ady    = (rsp_i.a.y >= rsp_i.b.y) ? COORD_W'(rsp_i.a.y - rsp_i.b.y)
                                      : COORD_W'(rsp_i.b.y - rsp_i.a.y);
    dist_d = {1'b0, adx} + {1'b0, ady};
  end

  // width check and sums only on the diagonal, where each entry shows once
  always_comb begin
    wide_bad = rsp_i.valid && rsp_i.diag &&
               (rsp_i.a.x >= $signed({1'b0, screen_width_i}));
    sum_x_d  = sum_x_q;
    sum_y_d  = sum_y_q;
    if (clear_i) begin
      sum_x_d = '0;
      sum_y_d = '0;
    end else if (rsp_i.valid && rsp_i.diag) begin
      sum_x_d = sum_x_q + {{(SUM_W-COORD_W){rsp_i.a.x[COORD_W-1]}}, rsp_i.a.x};
      sum_y_d = sum_y_q + {{(SUM_W-COORD_W){rsp_i.a.y[COORD_W-1]}}, rsp_i.a.y};
    end
  end

  // spread compare on the registered distance
  always_comb begin
    spread_bad = dist_v_q && (dist_q > max_spread_i);
    fail_d     = clear_i ? 1'b0 : (fail_q | wide_bad | spread_bad);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_v_q <= 1'b0;
      fail_q   <= 1'b0;
    end else begin
      dist_v_q <= rsp_i.valid && !clear_i;
      fail_q   <= fail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q  <= dist_d;
    sum_x_q <= sum_x_d;
    sum_y_q <= sum_y_d;
  end

  assign fail_o  = fail_q;
  assign busy_o  = dist_v_q;
  assign sum_x_o = sum_x_q;
  assign sum_y_o = sum_y_q;

endmodule : tsq_pair_unit

`default_nettype wire

/* design/tsq_div_unit.sv */
// Divider of a signed window sum by the window depth, quotient truncated toward
// zero, by reciprocal multiplication. Depends on tsq_pkg.
`default_nettype none

module tsq_div_unit
  import tsq_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [SUM_W-1:0] dividend_i,
  output logic                         done_o,
  output logic signed [COORD_W-1:0]    quot_o
);

  // the shift keeps the rounded-up reciprocal exact for every magnitude
  // below 2**MAG_W
  localparam int MAG_W     = SUM_W;
  localparam int DIV_SHIFT = MAG_W + $clog2(WINDOW_DEPTH);
  localparam int RECIP_W   = MAG_W + 1;
  localparam int PROD_W    = MAG_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_C =
    RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));

  logic               mul_q, done_q, neg_q;
  logic [MAG_W-1:0]   mag_q;
  logic [PROD_W-1:0]  prod;
  logic [COORD_W-1:0] quot_q;

  // magnitude times the reciprocal
  always_comb begin
    prod = {{RECIP_W{1'b0}}, mag_q} * {{MAG_W{1'b0}}, RECIP_C};
  end

  // multiply the cycle after start, done the cycle after that
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      mul_q  <= start_i;
      done_q <= mul_q;
    end
  end

  // sign and magnitude at start, quotient from the product
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[SUM_W-1];
      mag_q <= dividend_i[SUM_W-1] ? MAG_W'($unsigned(-dividend_i))
                                   : MAG_W'($unsigned(dividend_i));
    end
    if (mul_q) begin
      quot_q <= prod[DIV_SHIFT +: COORD_W];
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(quot_q) : $signed(quot_q);

endmodule : tsq_div_unit

`default_nettype wire

/* bench/tb_top.sv */
// Testbench of touch_stability_qualifier_unit: samples go in over the slave stream,
// each result beat is checked against an in-bench model of the window qualifier.
// Depends on tsq_pkg and the block itself.
`default_nettype none

module tb_top;
  import tsq_pkg::*;

  // one result beat as the block reports it
  typedef struct {
    logic                      stable;
    logic                      press;
    logic signed [COORD_W-1:0] avg_x;
    logic signed [COORD_W-1:0] avg_y;
  } touch_report_t;

  localparam int  NO_TOUCH_X = 2047;
  localparam int  MAX_SHOWN  = 10;
  localparam int  RAND_ITEMS = 470;

  logic                  clk_i;
  logic                  rst_n = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  sample_t               s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  sample_t               m_tdata;
  logic [1:0]            m_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // model state: window, re-arm counter and register copies
  logic signed [COORD_W-1:0] win_x [WINDOW_DEPTH];
  logic signed [COORD_W-1:0] win_y [WINDOW_DEPTH];
  logic [REARM_W-1:0]        rearm_cnt;
  logic [SW_W-1:0]           screen_width_q;
  logic [SPREAD_W-1:0]       max_spread_q;
  logic [REARM_W-1:0]        rearm_count_q;

  touch_report_t expected_reports[$];
  int  mismatch_cnt = 0;
  int  samples_sent = 0;
  bit  sink_hold    = 1'b0;
  bit  gaps_off     = 1'b0;
  int  sink_stall   = 0;

  touch_stability_qualifier_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .s_tdata_i  (s_tdata),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata),
    .m_tuser_o  (m_tuser),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // clock and single reset pulse
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
  end

  // run limit
  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

  // gap length: mostly none or short, a few long
  function automatic int pick_gap(int long_max);
    int r;
    r = $urandom_range(0, 99);
    if (gaps_off || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 98) return $urandom_range(5, 40);
    return $urandom_range(100, long_max);
  endfunction

  // shift in one sample, qualify the window, return the report it causes
  function automatic touch_report_t qualify_sample(sample_t smp);
    touch_report_t rep;
    bit ok;
    int sum_x, sum_y, dx, dy;
    ok = 1'b1;
    sum_x = 0;
    sum_y = 0;
    for (int i = WINDOW_DEPTH - 1; i > 0; i--) begin
      win_x[i] = win_x[i-1];
      win_y[i] = win_y[i-1];
    end
    win_x[0] = smp.x;
    win_y[0] = smp.y;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      if (int'(win_x[i]) >= int'(screen_width_q)) ok = 1'b0;
      for (int j = i + 1; j < WINDOW_DEPTH; j++) begin
        dx = int'(win_x[i]) - int'(win_x[j]);
        dy = int'(win_y[i]) - int'(win_y[j]);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (dx + dy > int'(max_spread_q)) ok = 1'b0;
      end
    end
    rep.stable = ok;
    rep.press  = 1'b0;
    rep.avg_x  = '0;
    rep.avg_y  = '0;
    if (ok) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        sum_x += int'(win_x[i]);
        sum_y += int'(win_y[i]);
      end
      // int division truncates toward zero
      rep.avg_x = COORD_W'(sum_x / WINDOW_DEPTH);
      rep.avg_y = COORD_W'(sum_y / WINDOW_DEPTH);
      rep.press = (rearm_cnt == '0);
      rearm_cnt = (rearm_count_q == '0) ? '0 : rearm_count_q - 1'b1;
    end else if (rearm_cnt != '0) begin
      rearm_cnt = rearm_cnt - 1'b1;
    end
    return rep;
  endfunction

  // result sink: random stalls, long hold when asked
  always @(negedge clk_i) begin
    if (sink_hold) begin
      m_tready <= 1'b0;
    end else if (sink_stall > 0) begin
      m_tready <= 1'b0;
      sink_stall = sink_stall - 1;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) sink_stall = pick_gap(600);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    touch_report_t exp_rep;
    touch_report_t got;
    if (rst_n && m_tvalid && m_tready) begin
      got.stable = m_tuser[0];
      got.press  = m_tuser[1];
      got.avg_x  = m_tdata.x;
      got.avg_y  = m_tdata.y;
      if (expected_reports.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_SHOWN)
          $display("%0t: result beat with nothing expected: stable %0d press %0d avg %0d,%0d",
                   $time, got.stable, got.press, got.avg_x, got.avg_y);
      end else begin
        exp_rep = expected_reports.pop_front();
        if (got.stable !== exp_rep.stable || got.press !== exp_rep.press ||
            got.avg_x !== exp_rep.avg_x || got.avg_y !== exp_rep.avg_y) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_SHOWN)
            $display("%0t: mismatch exp stable %0d press %0d avg %0d,%0d got %0d %0d %0d,%0d",
                     $time, exp_rep.stable, exp_rep.press, exp_rep.avg_x, exp_rep.avg_y,
                     got.stable, got.press, got.avg_x, got.avg_y);
        end
      end
    end
  end

  // offer one sample beat after a random gap, record its report on acceptance
  task automatic send_sample(int x, int y);
    int gap;
    gap = pick_gap(400);
    repeat (gap) begin
      @(negedge clk_i);
      s_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tdata  <= sample_t'{x: COORD_W'(x), y: COORD_W'(y)};
    do @(posedge clk_i); while (!(s_tvalid && s_tready));
    expected_reports.push_back(qualify_sample(s_tdata));
    samples_sent++;
  endtask

  // drop valid and wait until every report is back
  task automatic await_reports();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_DATA_W'(val);
    case (idx)
      CFG_SCREEN_WIDTH: screen_width_q = SW_W'(val);
      CFG_MAX_SPREAD:   max_spread_q   = SPREAD_W'(val);
      CFG_REARM_COUNT:  rearm_count_q  = REARM_W'(val);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(int sw, int spread, int rearm);
    write_reg(CFG_SCREEN_WIDTH, sw);
    write_reg(CFG_MAX_SPREAD, spread);
    write_reg(CFG_REARM_COUNT, rearm);
  endtask

  // a touch: samples jittered around one point, half extents a and b
  task automatic send_touch(int len, int a, int b);
    int lo, hi, cx, cy;
    lo = -2048 + a;
    hi = int'(screen_width_q) - 1 - a;
    if (hi > 2047 - a) hi = 2047 - a;
    if (hi < lo) hi = 2047 - a;
    cx = lo + int'($urandom_range(0, hi - lo));
    cy = -2048 + b + int'($urandom_range(0, 4095 - 2 * b));
    repeat (len)
      send_sample(cx - a + int'($urandom_range(0, 2 * a)),
                  cy - b + int'($urandom_range(0, 2 * b)));
  endtask

  // no-touch marker in x or plain random samples
  task automatic send_noise(int n);
    repeat (n) begin
      if ($urandom_range(0, 1))
        send_sample(NO_TOUCH_X, int'($urandom_range(0, 4095)) - 2048);
      else
        send_sample(int'($urandom_range(0, 4095)) - 2048,
                    int'($urandom_range(0, 4095)) - 2048);
    end
  endtask

  // window still full of the no-touch marker right after reset
  task automatic test_reset_window();
    send_sample(0, 0);
    send_sample(-5, 7);
    await_reports();
  endtask

  // widest screen width and spread, field extremes, negative sums truncated toward zero
  task automatic test_field_extremes();
    write_all(2047, 8191, 1);
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      case (i % 4)
        0: send_sample(-2048, -2048);
        1: send_sample(2046, 2047);
        2: send_sample(-1, 0);
        default: send_sample(0, -1);
      endcase
    end
    send_sample(NO_TOUCH_X, -2048);
    await_reports();
  endtask

  // zero screen width and zero re-arm count
  task automatic test_zero_width();
    write_all(0, 8191, 0);
    send_sample(0, 0);
    send_sample(-2048, 2047);
    await_reports();
  endtask

  // phases of touches and noise under changing register settings
  task automatic test_random_touches();
    int phase, r, sw, spread, rearm, half, a, b, len;
    phase = 0;
    while (samples_sent < RAND_ITEMS) begin
      if (phase == 0) begin
        sw = 2047; spread = 8191; rearm = 255;
      end else if (phase == 1) begin
        sw = 1; spread = 0; rearm = 0;
      end else begin
        r = $urandom_range(0, 9);
        sw = (r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 2047 : $urandom_range(200, 2047);
        r = $urandom_range(0, 9);
        spread = (r == 0) ? 0 : (r == 1) ? 8191 :
                 (r == 2) ? $urandom_range(1, 20) : $urandom_range(20, 3000);
        r = $urandom_range(0, 9);
        rearm = (r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 255 :
                (r < 6) ? $urandom_range(15, 40) : $urandom_range(1, 255);
      end
      write_all(sw, spread, rearm);
      gaps_off = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 3)) begin
        half = spread / 2;
        a = $urandom_range(0, (half < 1023) ? half : 1023);
        b = (half - a < 1023) ? half - a : 1023;
        // now and then just over the allowed spread
        if ($urandom_range(0, 5) == 0) a = a + 1;
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(18, 35) : $urandom_range(1, 17);
        send_touch(len, a, b);
        send_noise($urandom_range(0, 6));
      end
      gaps_off = 1'b0;
      await_reports();
      phase++;
    end
  endtask

  // result side held off while samples keep coming, input must stall
  task automatic test_sink_backpressure();
    write_all(1500, 400, 3);
    fork
      begin
        sink_hold = 1'b1;
        repeat (3000) @(posedge clk_i);
        sink_hold = 1'b0;
      end
      begin
        send_touch(22, 80, 90);
      end
    join
    await_reports();
  endtask

  // sender waits for every report before it goes on
  task automatic test_drain_pause();
    send_touch(6, 10, 10);
    await_reports();
    repeat (50) @(posedge clk_i);
    send_touch(6, 10, 10);
    await_reports();
  endtask

  // test sequence and final verdict
  initial begin
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      win_x[i] = NO_TOUCH;
      win_y[i] = NO_TOUCH;
    end
    rearm_cnt      = '0;
    screen_width_q = SCREEN_WIDTH_RST;
    max_spread_q   = MAX_SPREAD_RST;
    rearm_count_q  = REARM_COUNT_RST;
    @(posedge rst_n);
    @(posedge clk_i);
    test_reset_window();
    test_field_extremes();
    test_zero_width();
    test_random_touches();
    test_sink_backpressure();
    test_drain_pause();
    repeat (300) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule : tb_top

`default_nettype wire

/* touch_stability_qualifier_unit.f */
design/tsq_pkg.sv
design/tsq_window_mem.sv
design/tsq_pair_unit.sv
design/tsq_div_unit.sv
design/touch_stability_qualifier_unit.sv
bench/tb_top.sv
